@@ src/bdt_pkg.sv @@
`timescale 1ns / 1ps

package bdt_pkg;

    // Samples in one audio frame
    localparam int FRAME_SAMPLES = 80;

    // Field widths
    localparam int CARD_W   = 9;
    localparam int FILL_W   = 12;
    localparam int DELAY_W  = 14;
    localparam int MULT_W   = 2;
    localparam int RSDLY_W  = 8;
    localparam int GAP_W    = 16;
    localparam int COUNT_W  = 6;
    localparam int RAW_W    = 16;
    localparam int FRAME_W  = $clog2(FRAME_SAMPLES + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_MULT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESAMPLE_DELAY = 1'd1;

    // Stream widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Hysteresis constants
    localparam logic signed [GAP_W-1:0] GAP_HIGH = 16'sd224;
    localparam logic signed [GAP_W-1:0] GAP_LOW  = 16'sd96;
    localparam logic [COUNT_W-1:0] CHANGE_LIMIT  = 6'd25;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 6'd63;
    localparam logic [DELAY_W-1:0] DELAY_MARGIN  = 14'd160;

    // Raw delay estimate and the flush flag it implies
    typedef struct packed {
        logic signed [RAW_W-1:0] raw;
        logic                    flush;
    } raw_info_t;

endpackage

@@ src/bdt_raw_delay.sv @@
`timescale 1ns / 1ps

module bdt_raw_delay (
    input  logic [bdt_pkg::CARD_W-1:0]  card_ms,
    input  logic [bdt_pkg::FILL_W-1:0]  far_fill,
    input  logic                        resampling_on,
    input  logic [bdt_pkg::MULT_W-1:0]  rate_multiplier,
    input  logic [bdt_pkg::RSDLY_W-1:0] resample_delay,
    output bdt_pkg::raw_info_t          raw_info
);
    import bdt_pkg::*;

    logic [CARD_W+2:0]        card_samples;
    logic [CARD_W+4:0]        card_scaled;
    logic signed [RAW_W-1:0]  raw_base;
    logic signed [RAW_W-1:0]  raw_adj;
    logic signed [RAW_W-1:0]  frame_s;

    // card_ms * 8 * multiplier, a shift and a 2-bit multiply
    assign card_samples = {card_ms, 3'b000};
    assign card_scaled  = (CARD_W+5)'(card_samples) * (CARD_W+5)'(rate_multiplier);

    assign raw_base = $signed(RAW_W'(card_scaled)) - $signed(RAW_W'(far_fill))
                    - (resampling_on ? $signed(RAW_W'(resample_delay)) : '0);

    assign frame_s = $signed(RAW_W'(FRAME_SAMPLES));

    // Below one frame: ask for a flush and add a frame back
    always_comb begin
        raw_adj        = raw_base;
        raw_info.flush = 1'b0;
        if (raw_base < frame_s) begin
            raw_info.flush = 1'b1;
            raw_adj        = raw_base + frame_s;
        end
        raw_info.raw = raw_adj;
    end

endmodule

@@ src/bdt_tracker.sv @@
`timescale 1ns / 1ps

module bdt_tracker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         update_en,
    input  logic signed [bdt_pkg::RAW_W-1:0] raw,
    output logic [bdt_pkg::DELAY_W-1:0]  smoothed_next,
    output logic [bdt_pkg::DELAY_W-1:0]  known_next
);
    import bdt_pkg::*;

    localparam int SUM_W  = RAW_W + 3;
    localparam int DIV_W  = SUM_W - 1;
    localparam int RECIP_W = 16;
    localparam int PROD_W = DIV_W + RECIP_W;
    // ceil(2^18 / 5): exact quotient for dividends below 2^18
    localparam logic [RECIP_W-1:0] RECIP5 = 16'd52429;

    logic [DELAY_W-1:0]       filtered_reg;
    logic [DELAY_W-1:0]       applied_reg;
    logic signed [GAP_W-1:0]  prev_gap_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [COUNT_W-1:0]       count_next;

    logic signed [SUM_W-1:0]  sum;
    logic [PROD_W-1:0]        prod;
    logic signed [GAP_W-1:0]  gap;
    logic [COUNT_W-1:0]       count_inc;

    // Smoothing: (4*old + new) / 5, clamped at zero
    assign sum  = $signed({3'b000, filtered_reg, 2'b00}) + SUM_W'(raw);
    assign prod = PROD_W'(sum[DIV_W-1:0]) * PROD_W'(RECIP5);
    assign smoothed_next = sum[SUM_W-1] ? '0 : prod[18 +: DELAY_W];

    // Gap between smoothed and applied delay
    assign gap = $signed({2'b00, smoothed_next}) - $signed({2'b00, applied_reg});
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;

    always_comb begin
        if (gap > GAP_HIGH) begin
            count_next = (prev_gap_reg < GAP_LOW) ? '0 : count_inc;
        end else if (gap < GAP_LOW && applied_reg != '0) begin
            count_next = (prev_gap_reg > GAP_HIGH) ? '0 : count_inc;
        end else begin
            count_next = '0;
        end
    end

    // Jump the applied delay once the counter passes the limit
    always_comb begin
        known_next = applied_reg;
        if (count_next > CHANGE_LIMIT) begin
            known_next = (smoothed_next > DELAY_MARGIN) ? smoothed_next - DELAY_MARGIN : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filtered_reg <= '0;
            applied_reg  <= '0;
            prev_gap_reg <= '0;
            count_reg    <= '0;
        end else if (update_en) begin
            filtered_reg <= smoothed_next;
            applied_reg  <= known_next;
            prev_gap_reg <= gap;
            count_reg    <= count_next;
        end
    end

endmodule

@@ src/buffer_delay_tracker.sv @@
`timescale 1ns / 1ps

// Buffer delay tracker: one transfer per audio frame in, one result transfer out.
// Each frame item passes an input register, combinational update logic (raw delay,
// divide-by-five smoothing through a constant reciprocal multiply, hysteresis
// counter) and a result register; a new item is taken every cycle unless the
// result stream stalls; the filter and hysteresis state updates once per item,
// which is what bounds the rate at one item per clock. A full result register
// holds off new items only while m_tready is low. Configuration writes take
// effect on the next item and must be made while no item is in flight.
module buffer_delay_tracker (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration
    input  logic                               cfg_wr_en,
    input  logic [bdt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [8:0] card_ms, [20:9] far_fill, [21] resampling_on, [23:22] zero
    input  logic [bdt_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [13:0] known_delay, [14] flush_frame, [28:15] smoothed_delay, [31:29] zero
    output logic [bdt_pkg::M_TDATA_W-1:0]      m_tdata
);
    import bdt_pkg::*;

    logic [MULT_W-1:0]  rate_mult_reg;
    logic [RSDLY_W-1:0] resample_dly_reg;

    logic               in_valid_reg;
    logic [CARD_W-1:0]  card_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               resamp_reg;

    logic               out_valid_reg;
    logic [DELAY_W-1:0] known_reg;
    logic               flush_reg;
    logic [DELAY_W-1:0] smoothed_reg;

    logic               advance;
    raw_info_t          raw_info;
    logic [DELAY_W-1:0] smoothed_next;
    logic [DELAY_W-1:0] known_next;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_mult_reg    <= MULT_W'(1);
            resample_dly_reg <= RSDLY_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_RATE_MULT:      rate_mult_reg    <= cfg_wdata[MULT_W-1:0];
                REG_RESAMPLE_DELAY: resample_dly_reg <= cfg_wdata[RSDLY_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: stage moves when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            card_reg   <= s_tdata[CARD_W-1:0];
            fill_reg   <= s_tdata[CARD_W +: FILL_W];
            resamp_reg <= s_tdata[CARD_W+FILL_W];
        end
    end

    bdt_raw_delay u_raw (
        .card_ms         (card_reg),
        .far_fill        (fill_reg),
        .resampling_on   (resamp_reg),
        .rate_multiplier (rate_mult_reg),
        .resample_delay  (resample_dly_reg),
        .raw_info        (raw_info)
    );

    bdt_tracker u_trk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .update_en     (advance),
        .raw           (raw_info.raw),
        .smoothed_next (smoothed_next),
        .known_next    (known_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            known_reg    <= known_next;
            flush_reg    <= raw_info.flush;
            smoothed_reg <= smoothed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, smoothed_reg, flush_reg, known_reg};

endmodule
